/* design/rcdt_pkg.sv */
package rcdt_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int TILE_SIZE  = 16;

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int TILE_W  = $clog2(TILE_SIZE);
  localparam int TCOL_W  = COL_W - TILE_W;
  localparam int TROW_W  = ROW_W - TILE_W;
  localparam int ADDR_W  = ROW_W + COL_W;
  localparam int SIZE_W  = 11;
  localparam int PIX_W   = 32;
  localparam int RGB_W   = 16;
  localparam int TILE_COLS = MAX_WIDTH / TILE_SIZE;
  localparam int FS_DEPTH  = MAX_WIDTH * MAX_HEIGHT;

  localparam int OUT_DATA_BITS = RGB_W + TCOL_W + TROW_W;
  localparam int OUT_TDATA_W   = ((OUT_DATA_BITS + 7) / 8) * 8;
  localparam int OUT_PAD_W     = OUT_TDATA_W - OUT_DATA_BITS;
  localparam int OUT_TUSER_W   = 2;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_CHANGE_ONLY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

  localparam logic [SIZE_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = 11'd480;
  localparam logic [SIZE_W-1:0] WIDTH_MAX    = SIZE_W'(MAX_WIDTH);
  localparam logic [SIZE_W-1:0] HEIGHT_MAX   = SIZE_W'(MAX_HEIGHT);

  typedef struct packed {
    logic              frame_last;
    logic              tile_done;
    logic              tile_changed;
    logic [TROW_W-1:0] tile_row;
    logic [TCOL_W-1:0] tile_col;
    logic [RGB_W-1:0]  rgb565;
  } res_t;

endpackage

/* design/rcdt_out_queue.sv */
module rcdt_out_queue
  import rcdt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  res_t              push_data,
  output logic              out_valid,
  input  logic              out_ready,
  output res_t              out_data,
  output logic [QCNT_W-1:0] count
);

  res_t              q_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              pop;

  assign out_valid = (cnt_r != '0);
  assign out_data  = q_mem[rd_ptr_r];
  assign count     = cnt_r;
  assign pop       = out_valid && out_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* design/rgb565_convert_dirty_tiles_top.sv */
// Channel   Direction  Word layout (lowest bit first)
// in_*      slave      tdata: pixel[31:0] (blue, green, red, spare byte)
// out_*     master     tdata: rgb565, tile_col, tile_row, zero pad;
//                      tuser: tile_changed, tile_done; tlast: frame_last
// cfg_*     write      index 0 change_only, 1 frame_width, 2 frame_height
//
// One pixel word is taken per cycle while in_tready is high. Each word passes
// through the read stage (frame store and band dirty memory are read) and
// the update stage (compare, dirty bit merge, write back), then waits in a
// four-word output queue. After reset the frame store is cleared by a sweep
// over all of its words, one word per cycle, during which in_tready stays low.
// A stall on the output side fills the queue; in_tready drops only once the
// update stage and the queue together hold four words.
module rgb565_convert_dirty_tiles_top
  import rcdt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // Pixel input.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [PIX_W-1:0]       in_tdata,   // pixel
  // Result output.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // rgb565, tile_col, tile_row, pad
  output logic [OUT_TUSER_W-1:0] out_tuser,  // tile_changed, tile_done
  output logic                   out_tlast,  // frame_last
  // Configuration writes.
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [SIZE_W-1:0]      cfg_wdata
);

  // Configuration registers.
  logic              change_only_r;
  logic [SIZE_W-1:0] frame_width_r;
  logic [SIZE_W-1:0] frame_height_r;

  // Raster position of the next pixel.
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;

  // Clearing sweep over the frame store.
  logic              clr_active_r, clr_active_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;

  // Memories: previous frame and one dirty bit per tile column of the band.
  logic [PIX_W-1:0] fs_mem [FS_DEPTH];
  logic             bd_mem [TILE_COLS];
  logic [PIX_W-1:0] fs_rdata_r;
  logic             bd_rdata_r;

  // Read stage, combinational from the position and the incoming word.
  logic              in_accept;
  logic [SIZE_W-1:0] w_eff, h_eff;
  logic [SIZE_W-1:0] col_inc, row_inc;
  logic              s0_row_end, s0_frame_end, s0_last_row;
  logic              s0_tile_start, s0_tile_done;
  logic [ADDR_W-1:0] s0_addr;
  logic [TCOL_W-1:0] s0_tcol;
  logic [TROW_W-1:0] s0_trow;
  logic [RGB_W-1:0]  s0_rgb;

  // Update stage registers.
  logic              s1_valid_r;
  logic [PIX_W-1:0]  s1_pix_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic [TCOL_W-1:0] s1_tcol_r;
  logic [TROW_W-1:0] s1_trow_r;
  logic [RGB_W-1:0]  s1_rgb_r;
  logic              s1_cmp_r;
  logic              s1_start_r;
  logic              s1_done_r;
  logic              s1_last_r;
  logic              s1_fs_hit_r;
  logic [PIX_W-1:0]  s1_fs_fwd_r;
  logic              s1_bd_hit_r;
  logic              s1_bd_fwd_r;

  logic [PIX_W-1:0]  s1_prev;
  logic              s1_old_dirty;
  logic              s1_changed;
  res_t              s1_res;

  // Output queue.
  res_t              q_out;
  logic [QCNT_W-1:0] q_count;
  logic [QCNT_W-1:0] inflight;

  // Configuration writes; an index beyond the list is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      change_only_r  <= 1'b0;
      frame_width_r  <= WIDTH_RESET;
      frame_height_r <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CHANGE_ONLY:  change_only_r  <= cfg_wdata[0];
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata;
        REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // A size of zero counts as one; anything above the store's limit is capped.
  always_comb begin
    if (frame_width_r == '0) begin
      w_eff = SIZE_W'(1);
    end else if (frame_width_r > WIDTH_MAX) begin
      w_eff = WIDTH_MAX;
    end else begin
      w_eff = frame_width_r;
    end
    if (frame_height_r == '0) begin
      h_eff = SIZE_W'(1);
    end else if (frame_height_r > HEIGHT_MAX) begin
      h_eff = HEIGHT_MAX;
    end else begin
      h_eff = frame_height_r;
    end
  end

  // The queue plus the update stage never hold more than four words.
  assign inflight  = q_count + QCNT_W'(s1_valid_r);
  assign in_tready = !clr_active_r && (inflight < QCNT_W'(QDEPTH));
  assign in_accept = in_tvalid && in_tready;

  // Position decode. Positions at or past the last column end the row, which
  // also covers a width that shrank in the middle of a row.
  always_comb begin
    col_inc       = SIZE_W'(col_r) + 1'b1;
    row_inc       = SIZE_W'(row_r) + 1'b1;
    s0_row_end    = (col_inc >= w_eff);
    s0_last_row   = (row_inc >= h_eff);
    s0_frame_end  = s0_row_end && s0_last_row;
    s0_tile_start = (col_r[TILE_W-1:0] == '0) && (row_r[TILE_W-1:0] == '0);
    s0_tile_done  = (s0_row_end || (col_r[TILE_W-1:0] == '1)) &&
                    (s0_last_row || (row_r[TILE_W-1:0] == '1));
    s0_addr       = {row_r, col_r};
    s0_tcol       = col_r[COL_W-1:TILE_W];
    s0_trow       = row_r[ROW_W-1:TILE_W];
    s0_rgb        = {in_tdata[23:19], in_tdata[15:10], in_tdata[7:3]};

    col_nxt = col_r;
    row_nxt = row_r;
    if (in_accept) begin
      if (s0_frame_end) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (s0_row_end) begin
        col_nxt = '0;
        row_nxt = row_inc[ROW_W-1:0];
      end else begin
        col_nxt = col_inc[COL_W-1:0];
      end
    end
  end

  always_comb begin
    clr_active_nxt = clr_active_r;
    clr_addr_nxt   = clr_addr_r;
    if (clr_active_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_addr_r == '1) begin
        clr_active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r        <= '0;
      row_r        <= '0;
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
      s1_valid_r   <= 1'b0;
    end else begin
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      clr_active_r <= clr_active_nxt;
      clr_addr_r   <= clr_addr_nxt;
      s1_valid_r   <= in_accept;
    end
  end

  // Memory reads. The word in the update stage writes back on the same edge
  // that the next word reads, so a hit on the same entry is forwarded.
  always_ff @(posedge clk) begin
    fs_rdata_r <= fs_mem[s0_addr];
    bd_rdata_r <= bd_mem[s0_tcol];
    if (in_accept) begin
      s1_pix_r    <= in_tdata;
      s1_addr_r   <= s0_addr;
      s1_tcol_r   <= s0_tcol;
      s1_trow_r   <= s0_trow;
      s1_rgb_r    <= s0_rgb;
      s1_cmp_r    <= change_only_r;
      s1_start_r  <= s0_tile_start;
      s1_done_r   <= s0_tile_done;
      s1_last_r   <= s0_frame_end;
      s1_fs_hit_r <= s1_valid_r && s1_cmp_r && (s1_addr_r == s0_addr);
      s1_fs_fwd_r <= s1_pix_r;
      s1_bd_hit_r <= s1_valid_r && (s1_tcol_r == s0_tcol);
      s1_bd_fwd_r <= s1_changed;
    end
  end

  // Update stage: the tile's dirty bit restarts on its top-left pixel, then
  // any difference in the whole 32-bit word sets it. Full mode sets it always.
  always_comb begin
    s1_prev      = s1_fs_hit_r ? s1_fs_fwd_r : fs_rdata_r;
    s1_old_dirty = s1_bd_hit_r ? s1_bd_fwd_r : bd_rdata_r;
    if (s1_cmp_r) begin
      s1_changed = (s1_old_dirty && !s1_start_r) || (s1_prev != s1_pix_r);
    end else begin
      s1_changed = 1'b1;
    end
    s1_res.frame_last   = s1_last_r;
    s1_res.tile_done    = s1_done_r;
    s1_res.tile_changed = s1_changed;
    s1_res.tile_row     = s1_trow_r;
    s1_res.tile_col     = s1_tcol_r;
    s1_res.rgb565       = s1_rgb_r;
  end

  // Write ports: the clearing sweep owns them until it finishes.
  always_ff @(posedge clk) begin
    if (clr_active_r) begin
      fs_mem[clr_addr_r] <= '0;
      bd_mem[clr_addr_r[TCOL_W-1:0]] <= 1'b0;
    end else if (s1_valid_r) begin
      if (s1_cmp_r) begin
        fs_mem[s1_addr_r] <= s1_pix_r;
      end
      bd_mem[s1_tcol_r] <= s1_changed;
    end
  end

  rcdt_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_valid_r),
    .push_data (s1_res),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (q_out),
    .count     (q_count)
  );

  assign out_tdata = {{OUT_PAD_W{1'b0}}, q_out.tile_row, q_out.tile_col, q_out.rgb565};
  assign out_tuser = {q_out.tile_done, q_out.tile_changed};
  assign out_tlast = q_out.frame_last;

`ifndef SYNTHESIS
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> (q_count != QCNT_W'(QDEPTH)))
    else $error("output queue overflow");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> !in_accept)
    else $error("pixel accepted during frame store clear");

  a_full_mode_dirty: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_cmp_r) |-> s1_changed)
    else $error("full mode tile not marked changed");

  a_frame_end_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && s0_frame_end) |=> ((col_r == '0) && (row_r == '0)))
    else $error("position not reset after frame end");

  a_last_is_tile_done: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_last_r) |-> s1_done_r)
    else $error("frame end without tile done");
`endif

endmodule
